### hdl/precedence_order_checker_core_defines.svh
// Assertion macros for the precedence order checker.
// Included by every RTL file that carries concurrent assertions.
// Synthesis builds define SYNTH to drop the checks.
`ifndef PRECEDENCE_ORDER_CHECKER_CORE_DEFINES_SVH
`define PRECEDENCE_ORDER_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define POC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("poc assertion failed");

// Next-cycle implication.
`define POC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("poc assertion failed");

`else

`define POC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define POC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

### hdl/poc_pkg.sv
// Shared types and constants of the precedence order checker.
// No dependencies; used by the interfaces and all modules.
package poc_pkg;

	// Fixed field widths
	localparam int PAGE_W  = 7;
	localparam int TOTAL_W = 32;

	// Default sizes of the rule matrix and the row store
	localparam int PAGE_COUNT_DEF = 128;
	localparam int ROW_MAX_DEF    = 32;

	// Transaction kind carried in the mode field
	typedef enum logic {
		MODE_RULE = 1'b0,
		MODE_PAGE = 1'b1
	} mode_t;

endpackage

### hdl/poc_req_if.sv
// Input channel of the precedence order checker: rules and row pages.
// Depends on poc_pkg for field widths.
interface poc_req_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [poc_pkg::PAGE_W-1:0] first_page;
	logic [poc_pkg::PAGE_W-1:0] second_page;
	logic                       row_end;

	modport source (output valid, output mode, output first_page, output second_page,
		output row_end, input ready);
	modport sink (input valid, input mode, input first_page, input second_page,
		input row_end, output ready);
endinterface

### hdl/poc_rsp_if.sv
// Result channel of the precedence order checker: one transaction per row.
// Depends on poc_pkg for field widths.
interface poc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        row_valid;
	logic [poc_pkg::PAGE_W-1:0]  middle_page;
	logic [poc_pkg::TOTAL_W-1:0] total;

	modport source (output valid, output row_valid, output middle_page, output total,
		input ready);
	modport sink (input valid, input row_valid, input middle_page, input total,
		output ready);
endinterface

### hdl/poc_rel_mem.sv
// Precedence rule matrix: one row of PAGE_COUNT bits per page.
// Synchronous RAM, one read and one write port, zeroed by a sweep after reset.
module poc_rel_mem #(
	parameter int PAGE_COUNT = poc_pkg::PAGE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(PAGE_COUNT)-1:0] rd_addr,
	output logic [PAGE_COUNT-1:0]         rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(PAGE_COUNT)-1:0] wr_addr,
	input  logic [PAGE_COUNT-1:0]         wr_data,
	output logic                          clearing
);
	import poc_pkg::*;

	localparam int AW = $clog2(PAGE_COUNT);

	logic [PAGE_COUNT-1:0] mem [PAGE_COUNT];
	logic                  clr_q;
	logic [AW-1:0]         clr_cnt_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [PAGE_COUNT-1:0] mem_wd;

	// Clearing sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(PAGE_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Write port shared by the sweep and rule updates
	always_comb begin
		mem_we = clr_q || wr_en;
		mem_wa = clr_q ? clr_cnt_q : wr_addr;
		mem_wd = clr_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clr_q;

endmodule

### hdl/poc_row_mem.sv
// Row store: the pages of the current row, by position.
// Synchronous RAM with one write and one registered read port.
module poc_row_mem #(
	parameter int ROW_MAX = poc_pkg::ROW_MAX_DEF
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1)-1:0] wr_addr,
	input  logic [poc_pkg::PAGE_W-1:0]                 wr_data,
	input  logic                                       rd_en,
	input  logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1)-1:0] rd_addr,
	output logic [poc_pkg::PAGE_W-1:0]                 rd_data
);
	import poc_pkg::*;

	logic [PAGE_W-1:0] mem [ROW_MAX];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/precedence_order_checker_core.sv
// Precedence order checker. Rule transactions (mode 0) set "first_page before
// second_page" in a rule RAM; page transactions (mode 1) stream a row, each page
// checked against the pages already seen in that row. The last page of a row
// yields one result: validity, the page at index floor(length/2) (0 for rows
// longer than ROW_MAX, which are invalid) and the saturating sum of the middles
// of all valid rows. One transaction is accepted per cycle unless a result is
// stuck at the output: each needs a single read of the rule RAM, whose registered
// read is covered by forwarding the write made at the same edge. A result passes
// stage 1 and stage 2 into the output register. After reset the rule RAM is zeroed
// one row per cycle; no input is accepted until its PAGE_COUNT rows are clear.
`include "precedence_order_checker_core_defines.svh"

module precedence_order_checker_core #(
	parameter int PAGE_COUNT = poc_pkg::PAGE_COUNT_DEF,
	parameter int ROW_MAX    = poc_pkg::ROW_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	poc_req_if.sink     req,
	poc_rsp_if.source   rsp
);
	import poc_pkg::*;

	localparam int AW = $clog2(PAGE_COUNT);
	localparam int RW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
	localparam int LW = $clog2(ROW_MAX + 2);

	// Handshake and pipeline control
	logic                  adv;
	logic                  accept;
	logic                  clr_busy;

	// Stage 1: transaction waiting for its rule row
	logic                  valid_s1;
	logic                  mode_s1;
	logic [PAGE_W-1:0]     page_s1;
	logic [PAGE_W-1:0]     later_s1;
	logic                  end_s1;

	// Rule RAM ports and last-write forwarding
	logic [PAGE_COUNT-1:0] rel_rd;
	logic                  rule_we;
	logic [PAGE_COUNT-1:0] rule_wdata;
	logic                  wr_en_q;
	logic [AW-1:0]         wr_addr_q;
	logic [PAGE_COUNT-1:0] wr_data_q;
	logic [PAGE_COUNT-1:0] rel_row;

	// Row state
	logic [PAGE_COUNT-1:0] seen_q;
	logic [LW-1:0]         len_q;
	logic                  ok_q;

	// Stage 1 combinational results
	logic                  page_in;
	logic                  later_in;
	logic [PAGE_COUNT-1:0] later_bit;
	logic [PAGE_COUNT-1:0] page_bit;
	logic                  page_go;
	logic                  conflict;
	logic                  store;
	logic [LW-1:0]         len_n;
	logic                  ok_n;
	logic [PAGE_COUNT-1:0] seen_n;
	logic                  last;
	logic [LW-1:0]         mid_idx;
	logic                  fwd;

	// Stage 2: finished row waiting for its middle page
	logic                  valid_s2;
	logic                  ok_s2;
	logic                  over_s2;
	logic                  fwd_s2;
	logic [PAGE_W-1:0]     fwd_page_s2;
	logic [PAGE_W-1:0]     row_rd;
	logic [PAGE_W-1:0]     mid_s2;
	logic [TOTAL_W:0]      sum_s2;
	logic [TOTAL_W-1:0]    total_n;

	// Output register
	logic                  out_valid_q;
	logic                  row_valid_q;
	logic [PAGE_W-1:0]     mid_q;
	logic [TOTAL_W-1:0]    total_q;

	// Whole pipeline moves unless a result is stuck at the output
	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv && !clr_busy;
	assign accept    = req.valid && req.ready;

	poc_rel_mem #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_rel_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (AW'(req.first_page)),
		.rd_data  (rel_rd),
		.wr_en    (rule_we),
		.wr_addr  (AW'(page_s1)),
		.wr_data  (rule_wdata),
		.clearing (clr_busy)
	);

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= req.mode;
			page_s1  <= req.first_page;
			later_s1 <= req.second_page;
			end_s1   <= req.row_end;
		end
	end

	// Record the rule write made at each read edge for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_q <= 1'b0;
		end else if (adv) begin
			wr_en_q <= rule_we;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_addr_q <= AW'(page_s1);
			wr_data_q <= rule_wdata;
		end
	end

	// Stage 1: rule update or page check
	always_comb begin
		later_bit = '0;
		later_bit[AW'(later_s1)] = 1'b1;
		page_bit = '0;
		page_bit[AW'(page_s1)] = 1'b1;
		page_in  = 32'(page_s1) < 32'(PAGE_COUNT);
		later_in = 32'(later_s1) < 32'(PAGE_COUNT);
		rel_row  = (wr_en_q && (wr_addr_q == AW'(page_s1))) ? wr_data_q : rel_rd;

		rule_we    = adv && valid_s1 && (mode_s1 == MODE_RULE) && page_in && later_in;
		rule_wdata = rel_row | later_bit;

		page_go  = adv && valid_s1 && (mode_s1 == MODE_PAGE);
		conflict = page_in && (|(rel_row & seen_q));
		seen_n   = page_in ? (seen_q | page_bit) : seen_q;
		store    = len_q < LW'(ROW_MAX);
		len_n    = store ? (len_q + LW'(1)) : LW'(ROW_MAX + 1);
		ok_n     = ok_q && !conflict && store;
		last     = page_go && end_s1;
		mid_idx  = len_n >> 1;
		// Middle is the page being written now for rows of one or two pages
		fwd      = store && (mid_idx == len_q);
	end

	poc_row_mem #(
		.ROW_MAX (ROW_MAX)
	) u_row_mem (
		.clk     (clk),
		.wr_en   (page_go && store),
		.wr_addr (RW'(len_q)),
		.wr_data (page_s1),
		.rd_en   (last),
		.rd_addr (RW'(mid_idx)),
		.rd_data (row_rd)
	);

	// Row state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			len_q  <= '0;
			ok_q   <= 1'b1;
		end else if (page_go) begin
			if (end_s1) begin
				seen_q <= '0;
				len_q  <= '0;
				ok_q   <= 1'b1;
			end else begin
				seen_q <= seen_n;
				len_q  <= len_n;
				ok_q   <= ok_n;
			end
		end
	end

	// Stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (last) begin
			ok_s2       <= ok_n;
			over_s2     <= !store;
			fwd_s2      <= fwd;
			fwd_page_s2 <= page_s1;
		end
	end

	// Stage 2: middle page and saturating total
	always_comb begin
		if (over_s2) begin
			mid_s2 = '0;
		end else if (fwd_s2) begin
			mid_s2 = fwd_page_s2;
		end else begin
			mid_s2 = row_rd;
		end
		sum_s2  = {1'b0, total_q} + (TOTAL_W + 1)'(mid_s2);
		total_n = sum_s2[TOTAL_W] ? '1 : sum_s2[TOTAL_W-1:0];
	end

	// Output register and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
			if (valid_s2 && ok_s2) begin
				total_q <= total_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			row_valid_q <= ok_s2;
			mid_q       <= mid_s2;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.row_valid   = row_valid_q;
	assign rsp.middle_page = mid_q;
	assign rsp.total       = total_q;

	`POC_ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n, clr_busy, !req.ready)
	`POC_ASSERT_IMPL(a_len_bound, clk, arst_n, 1'b1, len_q <= LW'(ROW_MAX + 1))
	`POC_ASSERT_IMPL(a_overlong_invalid, clk, arst_n, valid_s2 && over_s2, !ok_s2)
	`POC_ASSERT_NEXT(a_total_hold_bad_row, clk, arst_n, adv && valid_s2 && !ok_s2, $stable(total_q))
	`POC_ASSERT_NEXT(a_row_end_clears, clk, arst_n, last, (len_q == '0) && (seen_q == '0) && ok_q)

endmodule

### tb/tb_precedence_order_checker_core.sv
// Self-checking testbench for precedence_order_checker_core: rule and row-page traffic
// in, per-row verdicts out, compared with a row-order scoreboard kept in this file.
// Depends on poc_pkg, poc_req_if, poc_rsp_if and the core from the RTL.
`timescale 1ns / 100ps

// Expected verdict of one finished row
typedef struct packed {
	bit                          row_valid;
	bit [poc_pkg::PAGE_W-1:0]    middle_page;
	bit [poc_pkg::TOTAL_W-1:0]   total;
} row_verdict_t;

// Tracks the rule matrix and the open row, and queues one verdict per finished row
class row_order_scoreboard;
	localparam int PAGES    = poc_pkg::PAGE_COUNT_DEF;
	localparam int ROW_SLOTS = poc_pkg::ROW_MAX_DEF;

	bit [PAGES-1:0]             must_precede [PAGES];  // [a][b]: a comes before b
	bit [PAGES-1:0]             seen_in_row;
	bit [poc_pkg::PAGE_W-1:0]   row_pages [ROW_SLOTS];
	int unsigned                row_len;
	bit                         row_ok;
	bit [poc_pkg::TOTAL_W-1:0]  middle_sum;
	row_verdict_t               pending_rows [$];
	int unsigned                errors;
	int unsigned                rules_taken;
	int unsigned                pages_taken;
	int unsigned                rows_checked;
	int unsigned                rows_valid;

	function new();
		row_len = 0;
		row_ok = 1'b1;
		middle_sum = '0;
		seen_in_row = '0;
	endfunction

	task flag_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		errors++;
	endtask

	// Apply one accepted request transaction; a row end queues a verdict
	function void note_transaction(input poc_pkg::mode_t kind,
		input bit [poc_pkg::PAGE_W-1:0] page, input bit [poc_pkg::PAGE_W-1:0] later,
		input bit last);
		row_verdict_t verdict;
		bit [poc_pkg::PAGE_W-1:0] mid;
		bit [poc_pkg::TOTAL_W:0] wide_sum;
		if (kind == poc_pkg::MODE_RULE) begin
			if (page < PAGES && later < PAGES)
				must_precede[page][later] = 1'b1;
			rules_taken++;
			return;
		end
		pages_taken++;
		if (page < PAGES) begin
			if ((must_precede[page] & seen_in_row) != '0)
				row_ok = 1'b0;
			seen_in_row[page] = 1'b1;
		end
		// store the page, or mark the row as overlong
		if (row_len < ROW_SLOTS) begin
			row_pages[row_len] = page;
			row_len++;
		end else begin
			row_len = ROW_SLOTS + 1;
			row_ok = 1'b0;
		end
		if (!last)
			return;
		mid = '0;
		if (row_len <= ROW_SLOTS && row_len / 2 < ROW_SLOTS)
			mid = row_pages[row_len / 2];
		// saturating sum of middles over valid rows
		if (row_ok) begin
			wide_sum = {1'b0, middle_sum} + (poc_pkg::TOTAL_W + 1)'(mid);
			middle_sum = wide_sum[poc_pkg::TOTAL_W] ? '1 : wide_sum[poc_pkg::TOTAL_W-1:0];
		end
		verdict.row_valid = row_ok;
		verdict.middle_page = mid;
		verdict.total = middle_sum;
		pending_rows = {pending_rows, verdict};
		seen_in_row = '0;
		row_len = 0;
		row_ok = 1'b1;
	endfunction

	// Compare one accepted result transaction with the oldest pending verdict
	task check_row_result(input logic valid_bit, input logic [poc_pkg::PAGE_W-1:0] mid,
		input logic [poc_pkg::TOTAL_W-1:0] sum);
		row_verdict_t want;
		if (pending_rows.size() == 0) begin
			flag_mismatch($sformatf("result (valid %b, middle %0d, total %0d) with no row open",
				valid_bit, mid, sum));
			return;
		end
		want = pending_rows.pop_front();
		rows_checked++;
		if (want.row_valid)
			rows_valid++;
		if (valid_bit !== want.row_valid)
			flag_mismatch($sformatf("row %0d: row_valid %b, expected %b",
				rows_checked, valid_bit, want.row_valid));
		if (mid !== want.middle_page)
			flag_mismatch($sformatf("row %0d: middle_page %0d, expected %0d",
				rows_checked, mid, want.middle_page));
		if (sum !== want.total)
			flag_mismatch($sformatf("row %0d: total %0d, expected %0d",
				rows_checked, sum, want.total));
	endtask
endclass

module tb_precedence_order_checker_core;
	import poc_pkg::*;

	localparam int ITEM_TARGET = 1200;
	localparam int CALM_FROM   = 1050;   // no idling from here on

	logic clk = 1'b0;
	logic arst_n;

	poc_req_if req ();
	poc_rsp_if rsp ();

	precedence_order_checker_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	row_order_scoreboard board = new();

	bit          src_idle_on;
	bit          sink_idle_on;
	int unsigned items_sent;
	bit [6:0]    rank_page [128];   // a hidden total order; rules mostly follow it

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result sink: ready with random stall bursts
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && sink_idle_on && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			rsp.ready <= arst_n;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_row_result(rsp.row_valid, rsp.middle_page, rsp.total);
	end

	// Drive one request transaction; called and returns at a falling edge
	task automatic send_item(input mode_t kind, input bit [6:0] page, input bit [6:0] later,
		input bit last);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.mode        <= kind;
		req.first_page  <= page;
		req.second_page <= later;
		req.row_end     <= last;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		board.note_transaction(kind, page, later, last);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every queued verdict has come back
	task automatic wait_rows_done();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (board.pending_rows.size() != 0);
	endtask

	// Mostly rules that agree with the hidden order, some arbitrary ones
	task automatic send_random_rule();
		int r1;
		int r2;
		if ($urandom_range(0, 99) < 85) begin
			r1 = $urandom_range(0, 126);
			r2 = r1 + $urandom_range(1, 8);
			if (r2 > 127)
				r2 = 127;
			send_item(MODE_RULE, rank_page[r1], rank_page[r2], 1'($urandom_range(0, 1)));
		end else begin
			send_item(MODE_RULE, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
				1'($urandom_range(0, 1)));
		end
	endtask

	// One row: ordered pages (optionally with swapped pairs) or fully random pages
	task automatic send_row(input int len, input bit ordered, input int swaps);
		bit [6:0] pages [48];
		bit [6:0] tmp;
		int r;
		int i;
		int j;
		int k;
		r = $urandom_range(0, 127);
		for (i = 0; i < len; i++) begin
			if (ordered) begin
				pages[i] = rank_page[r];
				r = r + $urandom_range(0, 3);
				if (r > 127)
					r = 127;
			end else begin
				pages[i] = 7'($urandom_range(0, 127));
			end
		end
		for (k = 0; k < swaps; k++) begin
			i = $urandom_range(0, len - 1);
			j = $urandom_range(0, len - 1);
			tmp = pages[i];
			pages[i] = pages[j];
			pages[j] = tmp;
		end
		for (i = 0; i < len; i++) begin
			// now and then a rule lands in the middle of the row
			if ($urandom_range(0, 11) == 0)
				send_random_rule();
			send_item(MODE_PAGE, pages[i], 7'($urandom_range(0, 127)), i == len - 1);
		end
	endtask

	// Stimulus and end of run
	initial begin
		int i;
		int j;
		int len;
		int pick;
		int drain_mark;
		int wait_cycles;
		bit [6:0] tmp;

		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.mode        = MODE_RULE;
		req.first_page  = '0;
		req.second_page = '0;
		req.row_end     = 1'b0;
		src_idle_on     = 1'b1;
		sink_idle_on    = 1'b1;
		items_sent      = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme pages, row_end on a rule, conflicts, repeats, rule inside a row
		send_item(MODE_RULE, 7'd0, 7'd127, 1'b1);
		send_item(MODE_RULE, 7'd5, 7'd5, 1'b0);
		send_item(MODE_PAGE, 7'd127, 7'd127, 1'b0);
		send_item(MODE_PAGE, 7'd0, 7'd0, 1'b1);       // 0 after 127: invalid
		send_item(MODE_PAGE, 7'd0, 7'd127, 1'b0);
		send_item(MODE_PAGE, 7'd127, 7'd0, 1'b1);     // valid, middle 127
		send_item(MODE_PAGE, 7'd5, 7'd0, 1'b0);
		send_item(MODE_PAGE, 7'd5, 7'd127, 1'b1);     // self rule, page repeated
		send_item(MODE_PAGE, 7'd42, 7'd85, 1'b1);     // single-page row
		send_item(MODE_PAGE, 7'd20, 7'd0, 1'b0);
		send_item(MODE_RULE, 7'd30, 7'd20, 1'b1);
		send_item(MODE_PAGE, 7'd30, 7'd0, 1'b1);      // rule added mid-row bites
		send_item(MODE_PAGE, 7'd85, 7'd42, 1'b0);
		send_item(MODE_PAGE, 7'd42, 7'd85, 1'b1);     // no rule between 85 and 42: valid, middle 42
		wait_rows_done();

		// Hidden order for the random part
		for (i = 0; i < 128; i++)
			rank_page[i] = 7'(i);
		for (i = 127; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = rank_page[i];
			rank_page[i] = rank_page[j];
			rank_page[j] = tmp;
		end

		// Full-length row, then two overlong ones, ordered and random
		send_row(32, 1'b1, 0);
		send_row(33, 1'b1, 0);
		send_row(40, 1'b0, 0);

		drain_mark = 400;
		while (items_sent < ITEM_TARGET) begin
			src_idle_on  = items_sent < CALM_FROM && (items_sent / 160) % 3 != 1;
			sink_idle_on = items_sent < CALM_FROM && (items_sent / 200) % 3 != 2;
			if (items_sent >= drain_mark) begin
				wait_rows_done();
				drain_mark += 400;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				repeat ($urandom_range(1, 6)) send_random_rule();
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				if (pick < 70)
					send_row(len, 1'b1, 0);
				else if (pick < 92)
					send_row(len, 1'b1, $urandom_range(1, 2));
				else
					send_row(len, 1'b0, 0);
			end
		end
		req.valid <= 1'b0;

		// Drain, then let the result pipeline settle
		wait_cycles = 0;
		while (board.pending_rows.size() != 0 && wait_cycles < 5000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (10) @(negedge clk);
		if (board.pending_rows.size() != 0)
			board.flag_mismatch($sformatf("%0d rows never reported",
				board.pending_rows.size()));

		$display("Sent %0d rules and %0d pages, overlong rows and mid-row rules included.",
			board.rules_taken, board.pages_taken);
		$display("Checked %0d row verdicts, %0d of them valid; running total %0d.",
			board.rows_checked, board.rows_valid, board.middle_sum);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/poc_pkg.sv
hdl/poc_req_if.sv
hdl/poc_rsp_if.sv
hdl/poc_rel_mem.sv
hdl/poc_row_mem.sv
hdl/precedence_order_checker_core.sv
tb/tb_precedence_order_checker_core.sv
